// ===== sv/mpvd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpvd_pkg
// Types, codes and helper functions for the marker-prefixed varint decoder.
// ----------------------------------------------------------------------------
package mpvd_pkg;

  localparam int unsigned CfgIndexWidth = 8;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_TARGET_WIDTH  = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_DEFAULT_VALUE = 8'd1;

  // target width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  // lead byte markers with a payload
  localparam logic [7:0] MARKER_LEN2 = 8'h91;  // -111
  localparam logic [7:0] MARKER_LEN3 = 8'h90;  // -112
  localparam logic [7:0] MARKER_LEN4 = 8'h8F;  // -113
  localparam logic [7:0] MARKER_LEN5 = 8'h8E;  // -114
  localparam logic [7:0] MARKER_LEN8 = 8'h8B;  // -117

  // lead bytes outside this range are literal values
  localparam logic [7:0] LITERAL_POS_MAX = 8'h7F;
  localparam logic [7:0] LITERAL_NEG_MIN = 8'h92;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TOO_WIDE    = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_e;

  // Payload length of a marker, zero when the marker is not supported.
  function automatic logic [3:0] marker_length(input logic [7:0] b);
    logic [3:0] len;
    unique case (b)
      MARKER_LEN2: len = 4'd2;
      MARKER_LEN3: len = 4'd3;
      MARKER_LEN4: len = 4'd4;
      MARKER_LEN5: len = 4'd5;
      MARKER_LEN8: len = 4'd8;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  // Smallest width code that accepts a payload of the given length.
  function automatic logic [1:0] needed_width(input logic [3:0] len);
    logic [1:0] w;
    priority if (len <= 4'd2) begin
      w = WIDTH_16;
    end else if (len <= 4'd4) begin
      w = WIDTH_32;
    end else begin
      w = WIDTH_64;
    end
    return w;
  endfunction

  // Sign-extend the low len bytes of v to 64 bits; a len other than 2 to 5 returns v as is.
  function automatic logic [63:0] sign_extend(input logic [63:0] v, input logic [3:0] len);
    logic [63:0] r;
    unique case (len)
      4'd2:    r = {{48{v[15]}}, v[15:0]};
      4'd3:    r = {{40{v[23]}}, v[23:0]};
      4'd4:    r = {{32{v[31]}}, v[31:0]};
      4'd5:    r = {{24{v[39]}}, v[39:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/marker_prefixed_varint_decoder.sv =====
// ----------------------------------------------------------------------------
// marker_prefixed_varint_decoder
// Decodes a byte stream of marker-prefixed variable-length signed integers.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and each byte is fully handled in the cycle it
// is accepted: a lead byte either yields a result at once or arms a payload
// counter, a payload byte is merged into a 64-bit accumulator. A result
// appears in the output register in the cycle after the byte that completes
// it, and the input keeps taking bytes while that register is drained, so
// the sustained rate is one byte per cycle; only a stalled output holds the
// input. Encodings wider than target_width still consume their payload and
// return default_value with status 1; unsupported markers return it at once
// with status 2. Configuration writes are always taken (cfg_ready_o is high).
// ----------------------------------------------------------------------------
module marker_prefixed_varint_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [1:0]  status_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mpvd_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [1:0]  target_width_q;
  logic [63:0] default_value_q;

  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [3:0]  payload_length_q, payload_length_d;
  logic [63:0] assembly_q, assembly_d;
  logic        reject_q, reject_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] value_q, value_d;
  mpvd_pkg::status_e status_q, status_d;

  logic        in_xfer;
  logic        res_valid;
  logic [3:0]  lead_len;
  logic [2:0]  pos;
  logic [63:0] merged;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  assign lead_len = mpvd_pkg::marker_length(in_byte_i);
  assign pos      = 3'(payload_length_q - bytes_left_q);
  assign merged   = assembly_q | (64'(in_byte_i) << {pos, 3'b000});

  always_comb begin
    bytes_left_d     = bytes_left_q;
    payload_length_d = payload_length_q;
    assembly_d       = assembly_q;
    reject_d         = reject_q;
    res_valid        = 1'b0;
    value_d          = value_q;
    status_d         = status_q;

    if (in_xfer) begin
      if (bytes_left_q == 4'd0) begin
        if (in_byte_i <= mpvd_pkg::LITERAL_POS_MAX || in_byte_i >= mpvd_pkg::LITERAL_NEG_MIN) begin
          res_valid = 1'b1;
          value_d   = {{56{in_byte_i[7]}}, in_byte_i};
          status_d  = mpvd_pkg::STATUS_OK;
        end else if (lead_len == 4'd0) begin
          res_valid = 1'b1;
          value_d   = default_value_q;
          status_d  = mpvd_pkg::STATUS_UNSUPPORTED;
        end else begin
          // take the width decision now; later writes do not change it
          payload_length_d = lead_len;
          bytes_left_d     = lead_len;
          assembly_d       = '0;
          reject_d         = target_width_q < mpvd_pkg::needed_width(lead_len);
        end
      end else begin
        bytes_left_d = bytes_left_q - 4'd1;
        assembly_d   = merged;
        if (bytes_left_q == 4'd1) begin
          res_valid = 1'b1;
          if (reject_q) begin
            value_d  = default_value_q;
            status_d = mpvd_pkg::STATUS_TOO_WIDE;
          end else begin
            value_d  = mpvd_pkg::sign_extend(merged, payload_length_q);
            status_d = mpvd_pkg::STATUS_OK;
          end
          reject_d         = 1'b0;
          payload_length_d = 4'd0;
          assembly_d       = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_width_q   <= mpvd_pkg::WIDTH_64;
      default_value_q  <= '0;
      bytes_left_q     <= '0;
      payload_length_q <= '0;
      assembly_q       <= '0;
      reject_q         <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mpvd_pkg::CFG_TARGET_WIDTH) begin
          target_width_q <= cfg_data_i[1:0];
        end else if (cfg_index_i == mpvd_pkg::CFG_DEFAULT_VALUE) begin
          default_value_q <= cfg_data_i;
        end
      end
      bytes_left_q     <= bytes_left_d;
      payload_length_q <= payload_length_d;
      assembly_q       <= assembly_d;
      reject_q         <= reject_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// ===== dv/varint_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_decode_checker
// Watches the byte, result and configuration channels of the decoder. It
// keeps its own copy of the decode state and the registers, and works out
// the results of the accepted bytes. Each returned result is compared field
// by field with the oldest one still due.
// ----------------------------------------------------------------------------
module varint_decode_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [7:0]                         in_byte_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [63:0]                        value_i,
  input  logic [1:0]                         status_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [mpvd_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [63:0]                        cfg_data_i,
  input  logic                               end_of_test_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output logic                               mid_item_o
);

  typedef struct packed {
    logic [63:0]       value;
    mpvd_pkg::status_e status;
  } decoded_t;

  decoded_t    due_q[$];
  logic [1:0]  width_sel;
  logic [63:0] dflt_value;
  logic [3:0]  left;
  logic [3:0]  plen;
  logic [63:0] acc;
  logic        reject;
  logic        closed;

  function automatic void note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t MISMATCH: %s", $time, msg);
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic [3:0]  len;
    int          shift;
    logic [63:0] ext;
    if (left == 4'd0) begin
      if (b <= mpvd_pkg::LITERAL_POS_MAX || b >= mpvd_pkg::LITERAL_NEG_MIN) begin
        due_q.push_back('{value: {{56{b[7]}}, b}, status: mpvd_pkg::STATUS_OK});
      end else begin
        unique case (b)
          mpvd_pkg::MARKER_LEN2: len = 4'd2;
          mpvd_pkg::MARKER_LEN3: len = 4'd3;
          mpvd_pkg::MARKER_LEN4: len = 4'd4;
          mpvd_pkg::MARKER_LEN5: len = 4'd5;
          mpvd_pkg::MARKER_LEN8: len = 4'd8;
          default:               len = 4'd0;
        endcase
        if (len == 4'd0) begin
          due_q.push_back('{value: dflt_value, status: mpvd_pkg::STATUS_UNSUPPORTED});
        end else begin
          // decide acceptance now; later width writes do not change it
          plen   = len;
          left   = len;
          acc    = '0;
          reject = (width_sel < mpvd_pkg::WIDTH_16) ||
                   (len > 4'd2 && width_sel < mpvd_pkg::WIDTH_32) ||
                   (len > 4'd4 && width_sel < mpvd_pkg::WIDTH_64);
        end
      end
    end else begin
      acc[8*(plen - left) +: 8] = b;
      left = left - 4'd1;
      if (left == 4'd0) begin
        if (reject) begin
          due_q.push_back('{value: dflt_value, status: mpvd_pkg::STATUS_TOO_WIDE});
        end else begin
          shift = 64 - 8 * plen;
          ext   = 64'($signed(acc << shift) >>> shift);
          due_q.push_back('{value: ext, status: mpvd_pkg::STATUS_OK});
        end
        reject = 1'b0;
        plen   = 4'd0;
        acc    = '0;
      end
    end
  endfunction

  function automatic void check_result();
    decoded_t want;
    if (due_q.size() == 0) begin
      note_failure($sformatf("unexpected result value=%h status=%0d", value_i, status_i));
    end else begin
      want = due_q.pop_front();
      if (value_i !== want.value) begin
        note_failure($sformatf("value expected %h actual %h", want.value, value_i));
      end
      if (status_i !== want.status) begin
        note_failure($sformatf("status expected %0d actual %0d", want.status, status_i));
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q.delete();
      width_sel    = mpvd_pkg::WIDTH_64;
      dflt_value   = '0;
      left         = 4'd0;
      plen         = 4'd0;
      acc          = '0;
      reject       = 1'b0;
      closed       = 1'b0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == mpvd_pkg::CFG_TARGET_WIDTH) begin
          width_sel = cfg_data_i[1:0];
        end else if (cfg_index_i == mpvd_pkg::CFG_DEFAULT_VALUE) begin
          dflt_value = cfg_data_i;
        end
      end
      // check the outgoing transfer before this edge's byte can queue anything
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        take_byte(in_byte_i);
      end
      if (end_of_test_i && !closed) begin
        closed = 1'b1;
        if (due_q.size() != 0) begin
          note_failure($sformatf("%0d results never returned", due_q.size()));
        end
      end
    end
    pending_o  = due_q.size();
    mid_item_o = (left != 4'd0);
  end

endmodule

// ===== dv/marker_prefixed_varint_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_prefixed_varint_decoder_tb
// Feeds a directed opening of edge values, bad markers and LEN2/LEN8, then
// phases of random encodings, literals, bad markers and noise under changing
// width and default settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module marker_prefixed_varint_decoder_tb;

  // unsupported lead bytes
  localparam logic [7:0] MK_RSVD_LO = 8'h80;  // -128
  localparam logic [7:0] MK_RSVD_HI = 8'h88;  // -120
  localparam logic [7:0] MK_ABSENT  = 8'h89;  // -119
  localparam logic [7:0] MK_NULL    = 8'h8A;  // -118
  localparam logic [7:0] MK_NEG116  = 8'h8C;
  localparam logic [7:0] MK_NEG115  = 8'h8D;

  localparam int PHASES     = 8;
  localparam int PHASE_SIZE = 230;

  localparam logic [7:0] OPENING [22] = '{
    mpvd_pkg::LITERAL_POS_MAX, 8'h00, mpvd_pkg::LITERAL_NEG_MIN, 8'hFF,
    MK_NEG115, MK_NEG116, MK_NULL, MK_ABSENT, MK_RSVD_LO, MK_RSVD_HI,
    mpvd_pkg::MARKER_LEN2, 8'h00, 8'h80,
    mpvd_pkg::MARKER_LEN8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F
  };

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic [7:0]                         in_byte;
  logic                               out_valid;
  logic                               out_ready;
  logic [63:0]                        value;
  logic [1:0]                         status;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [mpvd_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [63:0]                        cfg_data;
  logic                               end_check;
  logic                               calm;
  int                                 fail_count;
  int                                 pending;
  logic                               mid_item;
  int                                 sent;
  int                                 tx_span;
  logic                               tx_gaps;

  marker_prefixed_varint_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .value_o     (value),
    .status_o    (status),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  varint_decode_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_byte_i     (in_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .value_i       (value),
    .status_i      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .end_of_test_i (end_check),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .mid_item_o    (mid_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: stretches with and without stall bursts
  initial begin : rx_side
    int stall_left;
    int rx_span;
    logic rx_stalls;
    stall_left = 0;
    rx_span    = 0;
    rx_stalls  = 1'b0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_span == 0) begin
        rx_span   = $urandom_range(20, 80);
        rx_stalls = 1'($urandom_range(0, 1));
      end
      rx_span--;
      if (stall_left == 0 && rx_stalls && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Present one byte and hold it until the transfer; returns in that step.
  task automatic put_byte(input logic [7:0] b);
    if (tx_span == 0) begin
      tx_span = $urandom_range(20, 80);
      tx_gaps = 1'($urandom_range(0, 1));
    end
    tx_span--;
    if (tx_gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic put_encoding(input logic [7:0] marker, input int len);
    int kind;
    logic [7:0] b;
    kind = $urandom_range(0, 4);
    put_byte(marker);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0:       b = 8'($urandom);
        1:       b = 8'h00;
        2:       b = 8'hFF;
        3:       b = (i == len - 1) ? 8'h80 : 8'h00;  // most negative
        default: b = (i == len - 1) ? 8'h7F : 8'hFF;  // most positive
      endcase
      put_byte(b);
    end
  endtask

  task automatic put_random();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      put_byte(8'($urandom));
    end else if (pick < 30) begin
      b = 8'($urandom_range(MK_RSVD_LO, MK_NEG115));
      if (b == mpvd_pkg::MARKER_LEN8) b = MK_NULL;
      put_byte(b);
    end else if (pick < 45) begin
      b = 8'($urandom);
      // push marker bytes up into the negative literal range
      if (b > mpvd_pkg::LITERAL_POS_MAX && b < mpvd_pkg::LITERAL_NEG_MIN) b[6] = 1'b1;
      put_byte(b);
    end else begin
      case ($urandom_range(0, 4))
        0:       put_encoding(mpvd_pkg::MARKER_LEN2, 2);
        1:       put_encoding(mpvd_pkg::MARKER_LEN3, 3);
        2:       put_encoding(mpvd_pkg::MARKER_LEN4, 4);
        3:       put_encoding(mpvd_pkg::MARKER_LEN5, 5);
        default: put_encoding(mpvd_pkg::MARKER_LEN8, 8);
      endcase
    end
  endtask

  // Finish any open encoding, then hold until every result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (mid_item) begin
      @(posedge clk);
      put_byte(8'($urandom));
      in_valid <= 1'b0;
      @(negedge clk);
    end
    while (pending != 0) @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic cfg_write(input logic [mpvd_pkg::CfgIndexWidth-1:0] idx,
                           input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin : stimulus
    logic [63:0]                        data;
    logic [1:0]                         width_pick;
    int unsigned                        spare;
    logic [mpvd_pkg::CfgIndexWidth-1:0] spare_idx;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    end_check = 1'b0;
    calm      = 1'b0;
    sent      = 0;
    tx_span   = 0;
    tx_gaps   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING[i]) put_byte(OPENING[i]);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      width_pick = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      data       = {$urandom, $urandom};
      data[1:0]  = width_pick;
      cfg_write(mpvd_pkg::CFG_TARGET_WIDTH, data);
      case (p)
        0:       data = 64'h8000_0000_0000_0000;
        1:       data = 64'h7FFF_FFFF_FFFF_FFFF;
        2:       data = '1;
        default: data = {$urandom, $urandom};
      endcase
      cfg_write(mpvd_pkg::CFG_DEFAULT_VALUE, data);
      // an unused index must leave both registers alone
      if (p == 5) begin
        spare     = $urandom_range(2, 255);
        spare_idx = spare[mpvd_pkg::CfgIndexWidth-1:0];
        cfg_write(spare_idx, {$urandom, $urandom});
      end
      cfg_valid <= 1'b0;
      calm = (p == PHASES - 1);
      while (sent < (p + 1) * PHASE_SIZE + $size(OPENING)) put_random();
      settle();
    end

    end_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mpvd_pkg.sv
sv/marker_prefixed_varint_decoder.sv
dv/varint_decode_checker.sv
dv/marker_prefixed_varint_decoder_tb.sv
